### rtl/swrm_pkg.sv
// Shared types and constants of the sliding window rate meter.
// Holds the state encoding, opcodes, register indexes and bucket entry layout.
// No dependencies.
package swrm_pkg;

    // Field widths fixed by the interface.
    localparam int TIME_W    = 48;
    localparam int COUNT_W   = 32;
    localparam int AMOUNT_W  = 16;
    localparam int RATE_W    = 32;
    localparam int MS_W      = 16;
    localparam int FACTOR_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Item opcodes.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd2;

    // Register values after reset.
    localparam logic [MS_W-1:0]     WINDOW_RST = 16'd1000;
    localparam logic [MS_W-1:0]     BUCKET_RST = 16'd100;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 32'd524288;

    // One bucket as it sits in the bucket memory.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  stamp;
    } bucket_t;

    localparam int ENTRY_W = $bits(bucket_t);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CUT,
        ST_CHK,
        ST_WALK_CHK,
        ST_WALK_SUB,
        ST_WALK_LD,
        ST_SWEEP,
        ST_ADD,
        ST_ACC,
        ST_MUL,
        ST_WAIT,
        ST_OUT
    } state_t;

endpackage

### rtl/swrm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; every memory of the rate meter is an instance of it.
module swrm_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read; a read at the written address returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/swrm_scale.sv
// Scaling unit: total times the Q16.16 factor, rounded and saturated to 32 bits.
// Two pipeline stages; uses swrm_pkg for widths.
module swrm_scale (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [swrm_pkg::COUNT_W-1:0]   total,
    input  logic [swrm_pkg::FACTOR_W-1:0]  factor,
    output logic                           done,
    output logic [swrm_pkg::RATE_W-1:0]    rate
);

    localparam int PROD_W = swrm_pkg::COUNT_W + swrm_pkg::FACTOR_W;
    localparam int SUM_W  = PROD_W - 16 + 1;

    logic [PROD_W-1:0]           prod_reg;
    logic                        stage_reg;
    logic                        done_reg;
    logic [swrm_pkg::RATE_W-1:0] rate_reg;
    logic [SUM_W-1:0]            rounded;

    // Round half up at bit 15, carry kept one bit wider.
    assign rounded = {1'b0, prod_reg[PROD_W-1:16]} + {{(SUM_W-1){1'b0}}, prod_reg[15]};

    // Control pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    // Multiply, then round and saturate.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PROD_W'(total) * PROD_W'(factor);
        end
        if (stage_reg)
        begin
            if (rounded[SUM_W-1:swrm_pkg::RATE_W] != '0)
            begin
                rate_reg <= '1;
            end
            else
            begin
                rate_reg <= rounded[swrm_pkg::RATE_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign rate = rate_reg;

endmodule

### rtl/sliding_window_rate_meter.sv
// Sliding window rate meter: ring of time buckets in one RAM, read-modify-write
// sequencer and scaling unit. Depends on swrm_pkg, swrm_ram and swrm_scale.
//
// Each item is handled alone by a sequencer around the bucket RAM, whose
// registered read port sets the pace. An add passes the cutoff and expiry
// checks, then opens a new bucket or, to accumulate into the open one, reads
// it first. A query runs through the two-stage multiplier; one at the cached
// timestamp goes straight to the output. Each expiring bucket adds a walk step
// (read, subtract and clear, load the next start time). When the whole window
// has passed or the walk overruns the ring, a sweep over all BUCKETS entries
// clears the ring; after reset the same sweep runs before the first beat is
// accepted, while register writes are taken as ever. A finished rate waits in an
// output register, so the next beat can be accepted before it is taken.
module sliding_window_rate_meter #(
    parameter int BUCKETS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [swrm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swrm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [swrm_pkg::AMOUNT_W-1:0]     amount,
    input  logic [swrm_pkg::TIME_W-1:0]       now_ms,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [swrm_pkg::RATE_W-1:0]       rate
);

    localparam int SLOT_W = $clog2(BUCKETS);
    localparam int STEP_W = $clog2(BUCKETS + 1);
    localparam int TIME_W = swrm_pkg::TIME_W;

    // Sequencer and item registers.
    swrm_pkg::state_t state_reg, state_next;
    logic                           item_reg, item_next;
    logic                           op_reg, op_next;
    logic [swrm_pkg::AMOUNT_W-1:0]  amt_reg, amt_next;
    logic [TIME_W-1:0]              now_reg, now_next;
    logic [TIME_W-1:0]              cutoff_reg, cutoff_next;
    logic                           early_reg, early_next;
    logic [STEP_W-1:0]              step_reg, step_next;
    logic [SLOT_W-1:0]              sweep_reg, sweep_next;
    logic [swrm_pkg::RATE_W-1:0]    res_reg, res_next;

    // Configuration registers.
    logic [swrm_pkg::MS_W-1:0]      win_reg, win_next;
    logic [swrm_pkg::MS_W-1:0]      bkt_reg, bkt_next;
    logic [swrm_pkg::FACTOR_W-1:0]  fac_reg, fac_next;

    // Ring bookkeeping.
    logic [SLOT_W-1:0]              newest_slot_reg, newest_slot_next;
    logic                           newest_valid_reg, newest_valid_next;
    logic [SLOT_W-1:0]              oldest_slot_reg, oldest_slot_next;
    logic                           oldest_valid_reg, oldest_valid_next;
    logic [TIME_W-1:0]              newest_start_reg, newest_start_next;
    logic [TIME_W-1:0]              oldest_start_reg, oldest_start_next;
    logic [swrm_pkg::COUNT_W-1:0]   total_reg, total_next;
    logic [swrm_pkg::RATE_W-1:0]    cached_rate_reg, cached_rate_next;
    logic [TIME_W-1:0]              cached_time_reg, cached_time_next;

    // Output register.
    logic                           out_valid_reg, out_valid_next;
    logic [swrm_pkg::RATE_W-1:0]    rate_reg, rate_next;

    // Memory port and helpers.
    logic                           mem_we;
    logic [SLOT_W-1:0]              mem_waddr;
    swrm_pkg::bucket_t              mem_wdata;
    logic [SLOT_W-1:0]              mem_raddr;
    swrm_pkg::bucket_t              mem_rdata;
    logic [swrm_pkg::ENTRY_W-1:0]   mem_rdata_raw;
    logic [TIME_W:0]                cut_diff;
    logic [TIME_W-1:0]              age;
    logic                           open_new;
    logic [SLOT_W-1:0]              add_slot;
    logic [SLOT_W-1:0]              oldest_succ;
    logic [SLOT_W-1:0]              newest_succ;
    logic                           scale_start;
    logic                           scale_done;
    logic [swrm_pkg::RATE_W-1:0]    scale_rate;
    swrm_pkg::state_t               post_state;

    swrm_ram #(
        .WIDTH (swrm_pkg::ENTRY_W),
        .DEPTH (BUCKETS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata_raw)
    );

    assign mem_rdata = swrm_pkg::bucket_t'(mem_rdata_raw);

    swrm_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scale_start),
        .total  (total_reg),
        .factor (fac_reg),
        .done   (scale_done),
        .rate   (scale_rate)
    );

    // Slot successors around the ring.
    assign oldest_succ = (oldest_slot_reg == SLOT_W'(BUCKETS - 1)) ? '0
                       : oldest_slot_reg + SLOT_W'(1);
    assign newest_succ = (newest_slot_reg == SLOT_W'(BUCKETS - 1)) ? '0
                       : newest_slot_reg + SLOT_W'(1);

    // Cutoff with borrow, and the age of the open bucket.
    assign cut_diff = {1'b0, now_reg} - {{(TIME_W - swrm_pkg::MS_W + 1){1'b0}}, win_reg};
    assign age      = now_reg - newest_start_reg;
    assign open_new = !newest_valid_reg || (now_reg < newest_start_reg)
                   || (age >= {{(TIME_W - swrm_pkg::MS_W){1'b0}}, bkt_reg});
    assign add_slot = newest_valid_reg ? newest_succ : '0;

    // Where an item goes once expiry is done.
    assign post_state = (op_reg == swrm_pkg::OP_QUERY) ? swrm_pkg::ST_MUL : swrm_pkg::ST_ADD;

    assign in_ready  = (state_reg == swrm_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign rate      = rate_reg;

    // Next state and datapath.
    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        op_next           = op_reg;
        amt_next          = amt_reg;
        now_next          = now_reg;
        cutoff_next       = cutoff_reg;
        early_next        = early_reg;
        step_next         = step_reg;
        sweep_next        = sweep_reg;
        res_next          = res_reg;
        win_next          = win_reg;
        bkt_next          = bkt_reg;
        fac_next          = fac_reg;
        newest_slot_next  = newest_slot_reg;
        newest_valid_next = newest_valid_reg;
        oldest_slot_next  = oldest_slot_reg;
        oldest_valid_next = oldest_valid_reg;
        newest_start_next = newest_start_reg;
        oldest_start_next = oldest_start_reg;
        total_next        = total_reg;
        cached_rate_next  = cached_rate_reg;
        cached_time_next  = cached_time_reg;
        out_valid_next    = out_valid_reg;
        rate_next         = rate_reg;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = '0;
        mem_raddr         = oldest_slot_reg;
        scale_start       = 1'b0;

        // Register writes.
        if (cfg_wen)
        begin
            case (cfg_index)
                swrm_pkg::CFG_WINDOW: win_next = cfg_data[swrm_pkg::MS_W-1:0];
                swrm_pkg::CFG_BUCKET: bkt_next = cfg_data[swrm_pkg::MS_W-1:0];
                swrm_pkg::CFG_FACTOR: fac_next = cfg_data[swrm_pkg::FACTOR_W-1:0];
                default: ;
            endcase
        end

        // A taken result frees the output register.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            swrm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    amt_next   = amount;
                    now_next   = now_ms;
                    item_next  = 1'b1;
                    state_next = swrm_pkg::ST_CUT;
                end
            end

            // Stale adds, cached queries and the expiry cutoff.
            swrm_pkg::ST_CUT:
            begin
                cutoff_next = cut_diff[TIME_W-1:0];
                early_next  = cut_diff[TIME_W];
                if ((op_reg == swrm_pkg::OP_ADD) && (now_reg < oldest_start_reg))
                begin
                    item_next  = 1'b0;
                    state_next = swrm_pkg::ST_IDLE;
                end
                else if ((op_reg == swrm_pkg::OP_QUERY) && (now_reg == cached_time_reg))
                begin
                    res_next   = cached_rate_reg;
                    state_next = swrm_pkg::ST_OUT;
                end
                else
                begin
                    state_next = swrm_pkg::ST_CHK;
                end
            end

            // Decide between no expiry, a full clear and a bucket walk.
            swrm_pkg::ST_CHK:
            begin
                if (!newest_valid_reg || !oldest_valid_reg || early_reg
                    || (cutoff_reg < oldest_start_reg))
                begin
                    state_next = post_state;
                end
                else if (cutoff_reg >= newest_start_reg)
                begin
                    newest_slot_next  = '0;
                    newest_valid_next = 1'b0;
                    oldest_slot_next  = '0;
                    oldest_valid_next = 1'b0;
                    newest_start_next = '0;
                    oldest_start_next = '0;
                    total_next        = '0;
                    sweep_next        = '0;
                    state_next        = swrm_pkg::ST_SWEEP;
                end
                else
                begin
                    step_next  = '0;
                    state_next = swrm_pkg::ST_WALK_CHK;
                end
            end

            // One walk step: stop, give up on an overrun ring, or read the oldest bucket.
            swrm_pkg::ST_WALK_CHK:
            begin
                if (cutoff_reg < oldest_start_reg)
                begin
                    state_next = post_state;
                end
                else if (step_reg == STEP_W'(BUCKETS))
                begin
                    newest_slot_next  = '0;
                    newest_valid_next = 1'b0;
                    oldest_slot_next  = '0;
                    oldest_valid_next = 1'b0;
                    newest_start_next = '0;
                    oldest_start_next = '0;
                    total_next        = '0;
                    sweep_next        = '0;
                    state_next        = swrm_pkg::ST_SWEEP;
                end
                else
                begin
                    mem_raddr  = oldest_slot_reg;
                    state_next = swrm_pkg::ST_WALK_SUB;
                end
            end

            // Drop the oldest bucket and fetch its successor.
            swrm_pkg::ST_WALK_SUB:
            begin
                total_next       = total_reg - mem_rdata.count;
                mem_we           = 1'b1;
                mem_waddr        = oldest_slot_reg;
                mem_wdata        = '0;
                oldest_slot_next = oldest_succ;
                mem_raddr        = oldest_succ;
                step_next        = step_reg + STEP_W'(1);
                state_next       = swrm_pkg::ST_WALK_LD;
            end

            swrm_pkg::ST_WALK_LD:
            begin
                oldest_start_next = mem_rdata.stamp;
                state_next        = swrm_pkg::ST_WALK_CHK;
            end

            // Zero the bucket memory one entry a cycle.
            swrm_pkg::ST_SWEEP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = '0;
                sweep_next = sweep_reg + SLOT_W'(1);
                if (sweep_reg == SLOT_W'(BUCKETS - 1))
                begin
                    sweep_next = '0;
                    state_next = item_reg ? post_state : swrm_pkg::ST_IDLE;
                end
            end

            // Open a new bucket, or read the open one to accumulate.
            swrm_pkg::ST_ADD:
            begin
                if (open_new)
                begin
                    newest_slot_next  = add_slot;
                    newest_valid_next = 1'b1;
                    newest_start_next = now_reg;
                    mem_we            = 1'b1;
                    mem_waddr         = add_slot;
                    mem_wdata.count   = swrm_pkg::COUNT_W'(amt_reg);
                    mem_wdata.stamp   = now_reg;
                    if (!oldest_valid_reg)
                    begin
                        oldest_valid_next = 1'b1;
                        oldest_slot_next  = add_slot;
                        oldest_start_next = now_reg;
                    end
                    total_next       = total_reg + swrm_pkg::COUNT_W'(amt_reg);
                    cached_rate_next = '0;
                    cached_time_next = '0;
                    item_next        = 1'b0;
                    state_next       = swrm_pkg::ST_IDLE;
                end
                else
                begin
                    mem_raddr  = newest_slot_reg;
                    state_next = swrm_pkg::ST_ACC;
                end
            end

            swrm_pkg::ST_ACC:
            begin
                mem_we          = 1'b1;
                mem_waddr       = newest_slot_reg;
                mem_wdata.count = mem_rdata.count + swrm_pkg::COUNT_W'(amt_reg);
                mem_wdata.stamp = mem_rdata.stamp;
                if (!oldest_valid_reg)
                begin
                    oldest_valid_next = 1'b1;
                    oldest_slot_next  = newest_slot_reg;
                    oldest_start_next = now_reg;
                end
                total_next       = total_reg + swrm_pkg::COUNT_W'(amt_reg);
                cached_rate_next = '0;
                cached_time_next = '0;
                item_next        = 1'b0;
                state_next       = swrm_pkg::ST_IDLE;
            end

            // Scale the window total.
            swrm_pkg::ST_MUL:
            begin
                scale_start = 1'b1;
                state_next  = swrm_pkg::ST_WAIT;
            end

            swrm_pkg::ST_WAIT:
            begin
                if (scale_done)
                begin
                    res_next         = scale_rate;
                    cached_rate_next = scale_rate;
                    cached_time_next = now_reg;
                    state_next       = swrm_pkg::ST_OUT;
                end
            end

            // Hand the rate to the output register once it is free.
            swrm_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    rate_next      = res_reg;
                    item_next      = 1'b0;
                    state_next     = swrm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = swrm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and ring state; reset starts with a clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= swrm_pkg::ST_SWEEP;
            item_reg         <= 1'b0;
            step_reg         <= '0;
            sweep_reg        <= '0;
            win_reg          <= swrm_pkg::WINDOW_RST;
            bkt_reg          <= swrm_pkg::BUCKET_RST;
            fac_reg          <= swrm_pkg::FACTOR_RST;
            newest_slot_reg  <= '0;
            newest_valid_reg <= 1'b0;
            oldest_slot_reg  <= '0;
            oldest_valid_reg <= 1'b0;
            newest_start_reg <= '0;
            oldest_start_reg <= '0;
            total_reg        <= '0;
            cached_rate_reg  <= '0;
            cached_time_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            item_reg         <= item_next;
            step_reg         <= step_next;
            sweep_reg        <= sweep_next;
            win_reg          <= win_next;
            bkt_reg          <= bkt_next;
            fac_reg          <= fac_next;
            newest_slot_reg  <= newest_slot_next;
            newest_valid_reg <= newest_valid_next;
            oldest_slot_reg  <= oldest_slot_next;
            oldest_valid_reg <= oldest_valid_next;
            newest_start_reg <= newest_start_next;
            oldest_start_reg <= oldest_start_next;
            total_reg        <= total_next;
            cached_rate_reg  <= cached_rate_next;
            cached_time_reg  <= cached_time_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Item payload and result registers.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        amt_reg    <= amt_next;
        now_reg    <= now_next;
        cutoff_reg <= cutoff_next;
        early_reg  <= early_next;
        res_reg    <= res_next;
        rate_reg   <= rate_next;
    end

    // An oldest bucket exists only together with a newest one.
    a_valid_pair: assert property (@(posedge clk) disable iff (!rst_n)
        oldest_valid_reg |-> newest_valid_reg)
        else $error("oldest bucket valid without a newest bucket");

    // The walk never visits more buckets than the ring holds.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(BUCKETS))
        else $error("expiry walk ran past the ring size");

    // Clearing a bucket and fetching its successor never hit the same entry.
    a_walk_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swrm_pkg::ST_WALK_SUB) |-> (mem_waddr != mem_raddr))
        else $error("walk write and read collide in the bucket memory");

    // A computed rate is cached under the query time.
    a_cache_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swrm_pkg::ST_WAIT && scale_done) |=> (cached_time_reg == now_reg))
        else $error("cache time not updated after a computed rate");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding window rate meter: directed table, then random phases.
// Depends on swrm_pkg and sliding_window_rate_meter, and through it on swrm_ram and swrm_scale.
module tb_top;

    localparam int NUM_BUCKETS   = 16;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_BEATS   = 165;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    // Field widths taken from the package.
    localparam int TIME_W     = swrm_pkg::TIME_W;
    localparam int COUNT_W    = swrm_pkg::COUNT_W;
    localparam int AMOUNT_W   = swrm_pkg::AMOUNT_W;
    localparam int RATE_W     = swrm_pkg::RATE_W;
    localparam int MS_W       = swrm_pkg::MS_W;
    localparam int FACTOR_W   = swrm_pkg::FACTOR_W;
    localparam int CFG_IDX_W  = swrm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = swrm_pkg::CFG_DATA_W;

    // Index past the register list; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;
    typedef enum {ROW_BEAT, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic                   op;
        logic [AMOUNT_W-1:0]    amt;
        logic [TIME_W-1:0]      stamp;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  val;
        bit                     typed;
        logic [RATE_W-1:0]      want;
    } script_row_t;

    typedef struct {
        logic [MS_W-1:0]     win;
        logic [MS_W-1:0]     span;
        logic [FACTOR_W-1:0] scale;
        pace_t               pace;
    } phase_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  opcode;
    logic [AMOUNT_W-1:0]   amount;
    logic [TIME_W-1:0]     now_ms;
    logic                  out_valid;
    logic                  out_ready;
    logic [RATE_W-1:0]     rate;

    // Side band that travels with each input beat: a rate typed into the table.
    logic                  beat_typed;
    logic [RATE_W-1:0]     beat_typed_rate;

    pace_t                 pace;
    logic                  hold_req;
    script_row_t           script[$];
    phase_t                plan [NUM_PHASES];
    logic [TIME_W-1:0]     wall_ms;

    // Scoreboard and statistics.
    logic [RATE_W-1:0]     rates_owed[$];
    int                    results_due;
    int                    useful_beats;
    int                    stale_adds;
    int                    rates_checked;
    int                    settings_applied;
    int                    mismatches;
    int                    quiet_cycles;

    // Mirror of the meter: configuration, bucket ring and rate cache.
    logic [MS_W-1:0]       win_len;
    logic [MS_W-1:0]       span_len;
    logic [FACTOR_W-1:0]   scale;
    logic [COUNT_W-1:0]    bkt_bytes [NUM_BUCKETS];
    logic [TIME_W-1:0]     bkt_stamp [NUM_BUCKETS];
    int                    head_slot;
    int                    tail_slot;
    bit                    head_live;
    bit                    tail_live;
    logic [TIME_W-1:0]     head_start;
    logic [TIME_W-1:0]     tail_start;
    logic [COUNT_W-1:0]    total_bytes;
    logic [RATE_W-1:0]     memo_rate;
    logic [TIME_W-1:0]     memo_stamp;

    sliding_window_rate_meter #(
        .BUCKETS(NUM_BUCKETS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wen(cfg_wen),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .amount(amount),
        .now_ms(now_ms),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .rate(rate)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int ring_next(input int s);
        return (s + 1 >= NUM_BUCKETS) ? 0 : s + 1;
    endfunction

    // Empty the ring; the rate cache survives.
    function automatic void ring_wipe();
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            bkt_bytes[i] = '0;
            bkt_stamp[i] = '0;
        end
        head_slot   = 0;
        tail_slot   = 0;
        head_live   = 1'b0;
        tail_live   = 1'b0;
        head_start  = '0;
        tail_start  = '0;
        total_bytes = '0;
    endfunction

    // Drop buckets that fell out of the window ending at t.
    function automatic void ring_age(input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] cut;
        int                steps;
        if (!head_live || !tail_live)
            return;
        if (t < {32'd0, win_len})
            return;
        cut = t - {32'd0, win_len};
        if (cut < tail_start)
            return;
        if (cut >= head_start)
        begin
            ring_wipe();
            return;
        end
        steps = 0;
        while (cut >= tail_start)
        begin
            // The ring was overrun: the walk cannot reach the cutoff.
            if (steps >= NUM_BUCKETS)
            begin
                ring_wipe();
                return;
            end
            steps++;
            total_bytes          = total_bytes - bkt_bytes[tail_slot];
            bkt_bytes[tail_slot] = '0;
            bkt_stamp[tail_slot] = '0;
            tail_slot            = ring_next(tail_slot);
            tail_start           = bkt_stamp[tail_slot];
        end
    endfunction

    // Account an add beat; returns 0 when it is older than the oldest bucket.
    function automatic bit ring_add(input logic [AMOUNT_W-1:0] amt, input logic [TIME_W-1:0] t);
        if (t < tail_start)
            return 1'b0;
        ring_age(t);
        if (!head_live || t < head_start || t - head_start >= {32'd0, span_len})
        begin
            head_slot            = head_live ? ring_next(head_slot) : 0;
            head_live            = 1'b1;
            head_start           = t;
            bkt_bytes[head_slot] = {16'd0, amt};
            bkt_stamp[head_slot] = t;
        end
        else
        begin
            bkt_bytes[head_slot] = bkt_bytes[head_slot] + {16'd0, amt};
        end
        if (!tail_live)
        begin
            tail_live  = 1'b1;
            tail_slot  = head_slot;
            tail_start = t;
        end
        total_bytes = total_bytes + {16'd0, amt};
        memo_rate   = '0;
        memo_stamp  = '0;
        return 1'b1;
    endfunction

    // Rate seen by a query beat at time t, rounded half up and saturated.
    function automatic logic [RATE_W-1:0] ring_rate(input logic [TIME_W-1:0] t);
        logic [63:0] prod;
        logic [63:0] r;
        if (t == memo_stamp)
            return memo_rate;
        ring_age(t);
        prod       = {32'd0, total_bytes} * {32'd0, scale};
        r          = (prod >> 16) + ((prod >> 15) & 64'd1);
        memo_stamp = t;
        memo_rate  = (r > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
        return memo_rate;
    endfunction

    // Track register writes and beats on both channels, and check results.
    always @(posedge clk)
    begin : track
        logic [RATE_W-1:0] want;
        logic [RATE_W-1:0] owed;
        int                due_up;
        int                due_down;
        int                useful_up;
        if (!rst_n)
        begin
            win_len    = swrm_pkg::WINDOW_RST;
            span_len   = swrm_pkg::BUCKET_RST;
            scale      = swrm_pkg::FACTOR_RST;
            ring_wipe();
            memo_rate  = '0;
            memo_stamp = '0;
            rates_owed.delete();
            results_due  <= 0;
            useful_beats <= 0;
        end
        else
        begin
            due_up    = 0;
            due_down  = 0;
            useful_up = 0;
            if (cfg_wen)
            begin
                case (cfg_index)
                    swrm_pkg::CFG_WINDOW: win_len  = cfg_data[MS_W-1:0];
                    swrm_pkg::CFG_BUCKET: span_len = cfg_data[MS_W-1:0];
                    swrm_pkg::CFG_FACTOR: scale    = cfg_data[FACTOR_W-1:0];
                    default: ;
                endcase
            end
            // Results first: a result never belongs to a beat taken at the same edge.
            if (out_valid && out_ready)
            begin
                due_down = 1;
                rates_checked++;
                if (rates_owed.size() == 0)
                begin
                    $error("rate: unexpected beat, actual %08h", rate);
                    mismatches++;
                end
                else
                begin
                    owed = rates_owed.pop_front();
                    if (rate !== owed)
                    begin
                        $error("rate: expected %08h, actual %08h", owed, rate);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (opcode == swrm_pkg::OP_QUERY)
                begin
                    want = ring_rate(now_ms);
                    if (beat_typed)
                        want = beat_typed_rate;
                    rates_owed.push_back(want);
                    due_up    = 1;
                    useful_up = 1;
                end
                else if (ring_add(amount, now_ms))
                begin
                    useful_up = 1;
                end
                else
                begin
                    stale_adds++;
                end
            end
            results_due  <= results_due + due_up - due_down;
            useful_beats <= useful_beats + useful_up;
        end
    end

    // Result side: random stalls by pace, plus one long hold-off on request.
    initial
    begin : sink
        int held;
        held = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && held < HOLD_CYCLES)
            begin
                out_ready <= 1'b0;
                held++;
            end
            else
            begin
                case (pace)
                    PACE_RECV_STALLS: out_ready <= ($urandom_range(0, 99) >= 73);
                    PACE_BOTH:        out_ready <= ($urandom_range(0, 99) >= 27);
                    default:          out_ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog on cycles without any accepted beat or register write.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wen)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic plan_beat(input logic op, input logic [AMOUNT_W-1:0] amt,
                             input logic [TIME_W-1:0] t, input bit typed,
                             input logic [RATE_W-1:0] want);
        script_row_t row;
        row.kind  = ROW_BEAT;
        row.op    = op;
        row.amt   = amt;
        row.stamp = t;
        row.idx   = swrm_pkg::CFG_WINDOW;
        row.val   = '0;
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endtask

    task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        script_row_t row;
        row.kind  = ROW_REG;
        row.op    = swrm_pkg::OP_ADD;
        row.amt   = '0;
        row.stamp = '0;
        row.idx   = idx;
        row.val   = val;
        row.typed = 1'b0;
        row.want  = '0;
        script.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        settings_applied++;
    endtask

    // Offer one input beat, with a random gap first when the pace asks for it.
    task automatic send_beat(input logic op, input logic [AMOUNT_W-1:0] amt,
                             input logic [TIME_W-1:0] t, input bit typed,
                             input logic [RATE_W-1:0] want);
        int pct;
        pct = (pace == PACE_SEND_GAPS) ? 73 : (pace == PACE_BOTH) ? 27 : 0;
        if (pct > 0 && $urandom_range(0, 99) < pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < pct);
        end
        in_valid        <= 1'b1;
        opcode          <= op;
        amount          <= amt;
        now_ms          <= t;
        beat_typed      <= typed;
        beat_typed_rate <= want;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Let every rate drain and any trailing add finish before the block is touched.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One random beat: mostly time moving forward in bucket-sized steps.
    task automatic random_beat(input phase_t ph);
        logic [63:0]         wide;
        logic [TIME_W-1:0]   step;
        logic                op;
        logic [AMOUNT_W-1:0] amt;
        int                  span;
        int                  pick;
        int                  pick_amt;
        span = (ph.span == 0) ? 1 : int'(ph.span);
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            // Clear the ring with a query at the end of time, then jump anywhere.
            send_beat(swrm_pkg::OP_QUERY, 16'($urandom), TIME_MAX, 1'b0, '0);
            wide    = {$urandom, $urandom};
            wall_ms = wide[TIME_W-1:0];
            return;
        end
        if (pick < 7)
        begin
            step    = TIME_W'($urandom_range(0, 2 * span));
            wall_ms = wall_ms - step;
        end
        else if (pick < 11)
        begin
            step    = TIME_W'($urandom_range(0, 2 * span));
            wall_ms = wall_ms + {32'd0, ph.win} + step;
        end
        else if (pick >= 20)
        begin
            step    = TIME_W'($urandom_range(0, 2 * span));
            wall_ms = wall_ms + step;
        end
        op       = ($urandom_range(0, 99) < 35) ? swrm_pkg::OP_QUERY : swrm_pkg::OP_ADD;
        pick_amt = $urandom_range(0, 99);
        if (pick_amt < 10)
            amt = 16'hFFFF;
        else if (pick_amt < 20)
            amt = 16'h0000;
        else
            amt = 16'($urandom);
        send_beat(op, amt, wall_ms, 1'b0, '0);
    endtask

    initial
    begin : stimulus
        script_row_t row;
        bit          dirty;
        int          start_beats;
        rst_n           <= 1'b0;
        cfg_wen         <= 1'b0;
        cfg_index       <= swrm_pkg::CFG_WINDOW;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        opcode          <= swrm_pkg::OP_ADD;
        amount          <= '0;
        now_ms          <= '0;
        beat_typed      <= 1'b0;
        beat_typed_rate <= '0;
        pace            <= PACE_FULL;
        hold_req        <= 1'b0;
        stale_adds       = 0;
        rates_checked    = 0;
        settings_applied = 0;
        mismatches       = 0;
        wall_ms          = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings, then the register extremes.
        plan_beat(swrm_pkg::OP_QUERY, 16'd0, 48'd0, 1'b1, 32'd0);      // cache hit after reset
        plan_beat(swrm_pkg::OP_ADD, 16'hFFFF, 48'd0, 1'b0, '0);
        plan_beat(swrm_pkg::OP_QUERY, 16'd0, 48'd0, 1'b1, 32'd0);      // zero cache at time zero
        plan_beat(swrm_pkg::OP_QUERY, 16'd0, 48'd1, 1'b1, 32'd524280); // early time
        plan_beat(swrm_pkg::OP_ADD, 16'd0, 48'd50, 1'b0, '0);
        plan_beat(swrm_pkg::OP_ADD, 16'd1, 48'd99, 1'b0, '0);
        plan_beat(swrm_pkg::OP_ADD, 16'd100, 48'd100, 1'b0, '0);       // bucket length elapsed
        plan_beat(swrm_pkg::OP_ADD, 16'd7, 48'd60, 1'b0, '0);          // time going backwards
        plan_beat(swrm_pkg::OP_QUERY, 16'd0, 48'd999, 1'b0, '0);
        plan_beat(swrm_pkg::OP_QUERY, 16'd0, 48'd1000, 1'b0, '0);      // oldest bucket expires
        plan_beat(swrm_pkg::OP_ADD, 16'd5, 48'd50, 1'b0, '0);          // stale add
        plan_beat(swrm_pkg::OP_QUERY, 16'd0, 48'd1000, 1'b0, '0);      // stale add keeps cache
        plan_beat(swrm_pkg::OP_ADD, 16'd3, 48'd5000, 1'b0, '0);        // whole window passed
        plan_beat(swrm_pkg::OP_QUERY, 16'd0, 48'd5000, 1'b1, 32'd24);
        plan_beat(swrm_pkg::OP_QUERY, 16'd0, TIME_MAX, 1'b1, 32'd0);
        plan_beat(swrm_pkg::OP_ADD, 16'hFFFF, TIME_MAX, 1'b0, '0);
        plan_beat(swrm_pkg::OP_QUERY, 16'd0, TIME_MAX, 1'b1, 32'd524280);
        plan_beat(swrm_pkg::OP_ADD, 16'd1, 48'd0, 1'b0, '0);
        plan_beat(swrm_pkg::OP_QUERY, 16'd0, 48'd0, 1'b0, '0);
        plan_reg(swrm_pkg::CFG_FACTOR, 32'hFFFF_FFFF);
        plan_reg(CFG_SPARE, 32'hFFFF_FFFF);
        plan_beat(swrm_pkg::OP_ADD, 16'hFFFF, TIME_MAX, 1'b0, '0);
        plan_beat(swrm_pkg::OP_QUERY, 16'd0, TIME_MAX, 1'b1, 32'hFFFF_FFFF);  // saturation
        plan_reg(swrm_pkg::CFG_FACTOR, 32'd0);
        plan_beat(swrm_pkg::OP_QUERY, 16'd0, 48'h8000_0000_0000, 1'b1, 32'd0);
        plan_reg(swrm_pkg::CFG_BUCKET, 32'd0);
        plan_reg(swrm_pkg::CFG_WINDOW, 32'd0);
        plan_beat(swrm_pkg::OP_ADD, 16'd9, TIME_MAX, 1'b0, '0);        // zero window clears
        plan_beat(swrm_pkg::OP_ADD, 16'd9, TIME_MAX, 1'b0, '0);
        plan_reg(swrm_pkg::CFG_FACTOR, 32'h0001_0000);
        plan_beat(swrm_pkg::OP_QUERY, 16'd0, 48'h7FFF_FFFF_FFFF, 1'b1, 32'd9);

        dirty = 1'b0;
        foreach (script[i])
        begin
            row = script[i];
            if (row.kind == ROW_REG)
            begin
                if (dirty)
                    settle();
                dirty = 1'b0;
                write_reg(row.idx, row.val);
            end
            else
            begin
                send_beat(row.op, row.amt, row.stamp, row.typed, row.want);
                dirty = 1'b1;
            end
        end
        settle();

        // Random phases over a spread of settings and paces.
        plan[0] = '{16'd1000, 16'd100, 32'h0008_0000, PACE_FULL};
        plan[1] = '{16'd40, 16'd1, 32'h0000_8000, PACE_SEND_GAPS};
        plan[2] = '{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, PACE_RECV_STALLS};
        plan[3] = '{16'd1, 16'd0, 32'h0000_0001, PACE_BOTH};
        plan[4] = '{16'd300, 16'd7, $urandom, PACE_FULL};
        plan[5] = '{16'($urandom_range(1, 2000)), 16'($urandom_range(1, 200)), $urandom,
                    PACE_SEND_GAPS};
        plan[6] = '{16'd0, 16'd1, 32'h0001_0000, PACE_RECV_STALLS};
        plan[7] = '{16'd5000, 16'd600, $urandom, PACE_BOTH};
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            pace <= plan[p].pace;
            write_reg(swrm_pkg::CFG_WINDOW, {16'd0, plan[p].win});
            write_reg(swrm_pkg::CFG_BUCKET, {16'd0, plan[p].span});
            write_reg(swrm_pkg::CFG_FACTOR, plan[p].scale);
            write_reg(CFG_SPARE, $urandom);
            // Hold results off for a long stretch while beats keep coming.
            if (p == 0)
                hold_req <= 1'b1;
            start_beats = useful_beats;
            while (useful_beats - start_beats < PHASE_BEATS)
                random_beat(plan[p]);
            settle();
        end

        if (rates_owed.size() != 0)
        begin
            $error("rate: %0d expected beats never arrived", rates_owed.size());
            mismatches++;
        end
        $display("Run covered %0d useful beats and %0d stale adds, %0d rates checked.",
                 useful_beats, stale_adds, rates_checked);
        $display("Register writes: %0d, across %0d random settings and the directed extremes.",
                 settings_applied, NUM_PHASES);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
rtl/swrm_pkg.sv
rtl/swrm_ram.sv
rtl/swrm_scale.sv
rtl/sliding_window_rate_meter.sv
bench/tb_top.sv
